@@ hdl/tct_pkg.sv @@
// package with shared types and constants for the tunnel channel table
package tct_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = 4;

    localparam logic [15:0] MIN_CONNECT_LEN = 16'd26;
    localparam logic [15:0] MIN_CONTROL_LEN = 16'd16;

    localparam logic [2:0] OP_CONNECT = 3'd0;
    localparam logic [2:0] OP_STATE = 3'd1;
    localparam logic [2:0] OP_DISCONNECT = 3'd2;
    localparam logic [2:0] OP_TUNNEL = 3'd3;
    localparam logic [2:0] OP_SEND = 3'd4;

    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_CONNECT = 3'd1;
    localparam logic [2:0] KIND_ACK = 3'd4;
    localparam logic [2:0] KIND_TUNNEL_OUT = 3'd5;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_MORE = 3'd1;
    localparam logic [2:0] ST_INVALID = 3'd2;
    localparam logic [2:0] ST_SEQ_ERR = 3'd3;
    localparam logic [2:0] ST_REJECTED = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic [0:0] CFG_CHANNELS = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRUNE,
        S_SCAN,
        S_EXEC,
        S_COUNT,
        S_DONE
    } t_state;

endpackage

@@ hdl/tct_slot_mem.sv @@
// slot store: one entry read and one written per cycle, valid bits in flops
module tct_slot_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic [tct_pkg::SLOT_W-1:0] i_rd_idx,
    input  logic                       i_wr_en,
    input  logic [tct_pkg::SLOT_W-1:0] i_wr_idx,
    input  logic                       i_wr_valid,
    input  logic [31:0]                i_wr_addr,
    input  logic [15:0]                i_wr_port,
    input  logic [7:0]                 i_wr_rx,
    input  logic [7:0]                 i_wr_tx,
    input  logic [31:0]                i_wr_time,
    output logic                       o_rd_valid,
    output logic [31:0]                o_rd_addr,
    output logic [15:0]                o_rd_port,
    output logic [7:0]                 o_rd_rx,
    output logic [7:0]                 o_rd_tx,
    output logic [31:0]                o_rd_time
);
    import tct_pkg::*;

    logic [SLOT_COUNT-1:0] r_valid;
    logic [31:0] r_addr [SLOT_COUNT];
    logic [15:0] r_port [SLOT_COUNT];
    logic [7:0]  r_rx   [SLOT_COUNT];
    logic [7:0]  r_tx   [SLOT_COUNT];
    logic [31:0] r_time [SLOT_COUNT];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_idx] <= i_wr_valid;
        end
    end

    // payload store
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_addr[i_wr_idx] <= i_wr_addr;
            r_port[i_wr_idx] <= i_wr_port;
            r_rx[i_wr_idx]   <= i_wr_rx;
            r_tx[i_wr_idx]   <= i_wr_tx;
            r_time[i_wr_idx] <= i_wr_time;
        end
    end

    // combinational read of the selected slot
    assign o_rd_valid = r_valid[i_rd_idx];
    assign o_rd_addr  = r_addr[i_rd_idx];
    assign o_rd_port  = r_port[i_rd_idx];
    assign o_rd_rx    = r_rx[i_rd_idx];
    assign o_rd_tx    = r_tx[i_rd_idx];
    assign o_rd_time  = r_time[i_rd_idx];

endmodule

@@ hdl/tunnel_channel_table.sv @@
// Tunnel channel table. For each transfer a sequencer walks the slot store once to drop idle
// channels, once to look for an endpoint match or a free slot, then does one update and walks
// again to count live channels. The result sits in an output register; a new item is taken
// once it is handed off. Writing channels_in_use clears every slot.
module tunnel_channel_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [31:0] i_source_addr,
    input  logic [15:0] i_source_port,
    input  logic [7:0]  i_channel_id,
    input  logic [7:0]  i_sequence_req,
    input  logic [15:0] i_frame_length,
    input  logic        i_decode_ok,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_response_kind,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_channel,
    output logic [7:0]  o_out_sequence,
    output logic [31:0] o_dest_addr,
    output logic [15:0] o_dest_port,
    output logic        o_deliver,
    output logic [3:0]  o_active_count
);
    import tct_pkg::*;

    t_state r_state, n_state;
    logic [3:0]  r_chan_use;
    logic [31:0] r_timeout;
    logic [SLOT_W-1:0] r_idx;
    logic [2:0]  r_op;
    logic [31:0] r_saddr, r_now;
    logic [15:0] r_sport, r_flen;
    logic [7:0]  r_ch, r_seq;
    logic        r_dok;
    logic        r_match_f, r_free_f;
    logic [SLOT_W-1:0] r_match, r_free;
    logic [3:0]  r_cnt;
    logic        r_oval;

    logic [SLOT_W-1:0] rd_idx, wr_idx;
    logic wr_en, wr_valid;
    logic [31:0] wr_addr, wr_time;
    logic [15:0] wr_port;
    logic [7:0]  wr_rx, wr_tx;
    logic rd_valid;
    logic [31:0] rd_addr, rd_time;
    logic [15:0] rd_port;
    logic [7:0]  rd_rx, rd_tx;
    logic last, in_use, ep_eq;
    logic [3:0] n_slots;
    logic ch_ok;
    logic [SLOT_W-1:0] ch_idx;

    tct_slot_mem u_mem (
        .i_clk, .i_rst_n,
        .i_clear   (i_cfg_we && i_cfg_index == CFG_CHANNELS),
        .i_rd_idx  (rd_idx),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_valid(wr_valid),
        .i_wr_addr (wr_addr),
        .i_wr_port (wr_port),
        .i_wr_rx   (wr_rx),
        .i_wr_tx   (wr_tx),
        .i_wr_time (wr_time),
        .o_rd_valid(rd_valid),
        .o_rd_addr (rd_addr),
        .o_rd_port (rd_port),
        .o_rd_rx   (rd_rx),
        .o_rd_tx   (rd_tx),
        .o_rd_time (rd_time)
    );

    // shared compare terms
    assign n_slots = (r_chan_use > 4'(SLOT_COUNT)) ? 4'(SLOT_COUNT) : r_chan_use;
    assign last    = (r_idx == SLOT_W'(SLOT_COUNT - 1));
    assign in_use  = (4'(r_idx) < n_slots);
    assign ep_eq   = (rd_addr == r_saddr) && (rd_port == r_sport);
    assign ch_ok   = (r_ch != 8'd0) && ({4'd0, r_ch} <= 12'(n_slots));
    assign ch_idx  = SLOT_W'(r_ch - 8'd1);
    assign o_ready = (r_state == S_IDLE) && !r_oval;
    assign o_valid = r_oval;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && o_ready) n_state = S_PRUNE;
            S_PRUNE: if (last) n_state = S_SCAN;
            S_SCAN:  if (last) n_state = S_EXEC;
            S_EXEC:  n_state = S_COUNT;
            S_COUNT: if (last) n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // slot store access per state
    always_comb begin
        rd_idx = r_idx;
        wr_en = 1'b0; wr_idx = r_idx; wr_valid = rd_valid;
        wr_addr = rd_addr; wr_port = rd_port; wr_rx = rd_rx; wr_tx = rd_tx;
        wr_time = rd_time;
        unique case (r_state)
            S_PRUNE: begin
                if (r_timeout != 32'd0 && rd_valid && (r_now - rd_time) >= r_timeout) begin
                    wr_en = 1'b1; wr_valid = 1'b0;
                end
            end
            S_EXEC: begin
                priority case (r_op)
                    OP_CONNECT: begin
                        rd_idx = r_match_f ? r_match : r_free; wr_idx = rd_idx;
                        if (r_flen >= MIN_CONNECT_LEN && (r_match_f || r_free_f)) begin
                            wr_en = 1'b1; wr_time = r_now; wr_valid = 1'b1;
                            if (!r_match_f) begin
                                wr_addr = r_saddr; wr_port = r_sport;
                                wr_rx = 8'd0; wr_tx = 8'd0;
                            end
                        end
                    end
                    OP_STATE, OP_DISCONNECT, OP_TUNNEL: begin
                        rd_idx = ch_idx; wr_idx = ch_idx;
                        if (ch_ok && rd_valid && ep_eq &&
                            ((r_op == OP_TUNNEL) ? r_dok : (r_flen >= MIN_CONTROL_LEN))) begin
                            wr_en = 1'b1;
                            if (r_op == OP_DISCONNECT) wr_valid = 1'b0;
                            else wr_time = r_now;
                            if (r_op == OP_TUNNEL && r_seq == rd_rx) wr_rx = r_seq + 8'd1;
                        end
                    end
                    OP_SEND: begin
                        rd_idx = ch_idx; wr_idx = ch_idx;
                        if (ch_ok && rd_valid) begin
                            wr_en = 1'b1; wr_tx = rd_tx + 8'd1; wr_time = r_now;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // configuration, capture, scan and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_chan_use <= 4'd8; r_timeout <= 32'd0;
            r_idx <= '0; r_oval <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CHANNELS) r_chan_use <= i_cfg_data[3:0];
                else r_timeout <= i_cfg_data;
            end
            if (r_oval && i_ready) r_oval <= 1'b0;
            if (r_state == S_PRUNE || r_state == S_SCAN || r_state == S_COUNT)
                r_idx <= last ? '0 : r_idx + SLOT_W'(1);
            if (r_state == S_DONE) r_oval <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op <= i_operation; r_saddr <= i_source_addr; r_sport <= i_source_port;
                r_ch <= i_channel_id; r_seq <= i_sequence_req; r_flen <= i_frame_length;
                r_dok <= i_decode_ok; r_now <= i_now_ms;
                r_match_f <= 1'b0; r_free_f <= 1'b0; r_match <= '0; r_free <= '0;
                r_cnt <= 4'd0;
            end
            S_SCAN: begin
                if (in_use && rd_valid && ep_eq && !r_match_f) begin
                    r_match_f <= 1'b1; r_match <= r_idx;
                end
                if (in_use && !rd_valid && !r_free_f) begin
                    r_free_f <= 1'b1; r_free <= r_idx;
                end
            end
            S_EXEC: begin
                o_response_kind <= KIND_NONE; o_status <= ST_OK; o_out_channel <= 8'd0;
                o_out_sequence <= 8'd0; o_dest_addr <= 32'd0; o_dest_port <= 16'd0;
                o_deliver <= 1'b0;
                priority case (r_op)
                    OP_CONNECT: begin
                        if (r_flen < MIN_CONNECT_LEN) o_status <= ST_REJECTED;
                        else begin
                            o_response_kind <= KIND_CONNECT;
                            o_dest_addr <= r_saddr; o_dest_port <= r_sport;
                            if (r_match_f) o_out_channel <= 8'(r_match) + 8'd1;
                            else if (r_free_f) o_out_channel <= 8'(r_free) + 8'd1;
                            else o_status <= ST_NO_MORE;
                        end
                    end
                    OP_STATE, OP_DISCONNECT: begin
                        if (r_flen < MIN_CONTROL_LEN) o_status <= ST_REJECTED;
                        else begin
                            o_response_kind <= r_op + 3'd1;
                            o_dest_addr <= r_saddr; o_dest_port <= r_sport;
                            o_out_channel <= r_ch;
                            if (!(ch_ok && rd_valid && ep_eq)) o_status <= ST_INVALID;
                        end
                    end
                    OP_TUNNEL: begin
                        if (!r_dok) o_status <= ST_REJECTED;
                        else begin
                            o_response_kind <= KIND_ACK;
                            o_dest_addr <= r_saddr; o_dest_port <= r_sport;
                            o_out_channel <= r_ch; o_out_sequence <= r_seq;
                            if (!(ch_ok && rd_valid && ep_eq)) o_status <= ST_INVALID;
                            else if (r_seq != rd_rx) o_status <= ST_SEQ_ERR;
                            else o_deliver <= 1'b1;
                        end
                    end
                    OP_SEND: begin
                        if (!(ch_ok && rd_valid)) o_status <= ST_UNKNOWN;
                        else begin
                            o_response_kind <= KIND_TUNNEL_OUT; o_out_channel <= r_ch;
                            o_out_sequence <= rd_tx; o_dest_addr <= rd_addr;
                            o_dest_port <= rd_port;
                        end
                    end
                    default: ;
                endcase
            end
            S_COUNT: if (in_use && rd_valid) r_cnt <= r_cnt + 4'd1;
            S_DONE:  o_active_count <= r_cnt;
            default: ;
        endcase
    end

    // a result is never shown while a new item is being taken
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready with result pending");
    a_done_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> o_valid) else $error("result lost");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_active_count <= 4'(SLOT_COUNT)) else $error("count too large");
    a_deliver_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_deliver) |-> (o_response_kind == KIND_ACK && o_status == ST_OK))
        else $error("deliver without ok ack");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the tunnel channel table
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tct_pkg::*;

    // codes the package does not name
    localparam logic [2:0] OP_TICK = 3'd5;
    localparam logic [2:0] OP_TICK_ALT6 = 3'd6;
    localparam logic [2:0] OP_TICK_ALT7 = 3'd7;
    localparam logic [2:0] KIND_STATE = 3'd2;
    localparam logic [2:0] KIND_DISCONNECT = 3'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  ch;
        logic [7:0]  seq;
        logic [15:0] flen;
        logic        dok;
        logic [31:0] now;
    } t_frame;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  status;
        logic [7:0]  ch;
        logic [7:0]  seq;
        logic [31:0] addr;
        logic [15:0] port;
        logic        dlv;
        logic [3:0]  cnt;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_operation = '0;
    logic [31:0] i_source_addr = '0;
    logic [15:0] i_source_port = '0;
    logic [7:0]  i_channel_id = '0;
    logic [7:0]  i_sequence_req = '0;
    logic [15:0] i_frame_length = '0;
    logic        i_decode_ok = 1'b0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_response_kind;
    logic [2:0]  o_status;
    logic [7:0]  o_out_channel;
    logic [7:0]  o_out_sequence;
    logic [31:0] o_dest_addr;
    logic [15:0] o_dest_port;
    logic        o_deliver;
    logic [3:0]  o_active_count;

    tunnel_channel_table u_top (.*);

    // mirror of the channel table
    logic        tbl_valid [SLOT_COUNT];
    logic [31:0] tbl_addr [SLOT_COUNT];
    logic [15:0] tbl_port [SLOT_COUNT];
    logic [7:0]  tbl_rx_seq [SLOT_COUNT];
    logic [7:0]  tbl_tx_seq [SLOT_COUNT];
    logic [31:0] tbl_last [SLOT_COUNT];
    logic [3:0]  tbl_channels;
    logic [31:0] tbl_timeout;

    t_response   pending_responses[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [31:0] clock_ms = 32'd1000;
    logic [31:0] peer_addr [6];
    logic [15:0] peer_port [6];

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int table_depth();
        return (tbl_channels > SLOT_COUNT) ? SLOT_COUNT : int'(tbl_channels);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_addr[i] = '0;
            tbl_port[i] = '0;
            tbl_rx_seq[i] = '0;
            tbl_tx_seq[i] = '0;
            tbl_last[i] = '0;
        end
    endfunction

    // slot index of a live channel id, or -1
    function automatic int live_slot(logic [7:0] ch);
        if (ch == 0 || ch > table_depth()) return -1;
        if (!tbl_valid[ch - 1]) return -1;
        return int'(ch) - 1;
    endfunction

    function automatic logic peer_matches(int s, logic [31:0] a, logic [15:0] p);
        return tbl_addr[s] == a && tbl_port[s] == p;
    endfunction

    // computes the response of one frame and updates the mirror
    function automatic t_response apply_frame(t_frame f);
        t_response r;
        int s;
        int depth;
        depth = table_depth();
        r = '0;
        // drop idle channels
        if (tbl_timeout != 0) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (tbl_valid[i] && (f.now - tbl_last[i]) >= tbl_timeout) tbl_valid[i] = 1'b0;
        end
        case (f.op)
            OP_CONNECT: begin
                if (f.flen < MIN_CONNECT_LEN) begin
                    r.status = ST_REJECTED;
                end else begin
                    s = -1;
                    for (int i = 0; i < depth && s < 0; i++)
                        if (tbl_valid[i] && peer_matches(i, f.addr, f.port)) s = i;
                    for (int i = 0; i < depth && s < 0; i++) begin
                        if (!tbl_valid[i]) begin
                            s = i;
                            tbl_valid[i] = 1'b1;
                            tbl_addr[i] = f.addr;
                            tbl_port[i] = f.port;
                            tbl_rx_seq[i] = '0;
                            tbl_tx_seq[i] = '0;
                        end
                    end
                    r.kind = KIND_CONNECT;
                    r.addr = f.addr;
                    r.port = f.port;
                    if (s < 0) begin
                        r.status = ST_NO_MORE;
                    end else begin
                        tbl_last[s] = f.now;
                        r.ch = 8'(s + 1);
                    end
                end
            end
            OP_STATE, OP_DISCONNECT: begin
                if (f.flen < MIN_CONTROL_LEN) begin
                    r.status = ST_REJECTED;
                end else begin
                    r.kind = (f.op == OP_STATE) ? KIND_STATE : KIND_DISCONNECT;
                    r.addr = f.addr;
                    r.port = f.port;
                    r.ch = f.ch;
                    s = live_slot(f.ch);
                    if (s < 0 || !peer_matches(s, f.addr, f.port)) r.status = ST_INVALID;
                    else if (f.op == OP_STATE) tbl_last[s] = f.now;
                    else tbl_valid[s] = 1'b0;
                end
            end
            OP_TUNNEL: begin
                if (!f.dok) begin
                    r.status = ST_REJECTED;
                end else begin
                    r.kind = KIND_ACK;
                    r.addr = f.addr;
                    r.port = f.port;
                    r.ch = f.ch;
                    r.seq = f.seq;
                    s = live_slot(f.ch);
                    if (s < 0 || !peer_matches(s, f.addr, f.port)) begin
                        r.status = ST_INVALID;
                    end else begin
                        tbl_last[s] = f.now;
                        if (f.seq != tbl_rx_seq[s]) begin
                            r.status = ST_SEQ_ERR;
                        end else begin
                            tbl_rx_seq[s] = f.seq + 8'd1;
                            r.dlv = 1'b1;
                        end
                    end
                end
            end
            OP_SEND: begin
                s = live_slot(f.ch);
                if (s < 0) begin
                    r.status = ST_UNKNOWN;
                end else begin
                    r.kind = KIND_TUNNEL_OUT;
                    r.ch = f.ch;
                    r.seq = tbl_tx_seq[s];
                    r.addr = tbl_addr[s];
                    r.port = tbl_port[s];
                    tbl_tx_seq[s] = tbl_tx_seq[s] + 8'd1;
                    tbl_last[s] = f.now;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < depth; i++)
            if (tbl_valid[i]) r.cnt = r.cnt + 4'd1;
        return r;
    endfunction

    // receiver stalls in randomly chosen modes
    int ready_mode = 0;
    int ready_mode_left = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (ready_mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(50, 400);
        end else begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 4) == 0);
            default: i_ready <= ((cycle_count % 16) < 10);
        endcase
    end

    // response checker
    always @(posedge i_clk) begin
        t_response got;
        t_response want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_response_kind, o_status, o_out_channel, o_out_sequence,
                    o_dest_addr, o_dest_port, o_deliver, o_active_count};
            if (pending_responses.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected response transfer kind=%0d status=%0d",
                             got.kind, got.status);
            end else begin
                want = pending_responses.pop_front();
                if (got !== want) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10) begin
                        $display("mismatch kind %0d/%0d status %0d/%0d ch %0d/%0d seq %0d/%0d",
                                 want.kind, got.kind, want.status, got.status,
                                 want.ch, got.ch, want.seq, got.seq);
                        $display("  addr %h/%h port %h/%h deliver %0d/%0d count %0d/%0d",
                                 want.addr, got.addr, want.port, got.port,
                                 want.dlv, got.dlv, want.cnt, got.cnt);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // one frame transfer, with a random gap at the end of each burst
    task automatic send_frame(t_frame f);
        int gap;
        t_response expect_resp;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        burst_left = burst_left - 1;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_operation, i_source_addr, i_source_port, i_channel_id, i_sequence_req,
         i_frame_length, i_decode_ok, i_now_ms} <= f;
        do @(posedge i_clk); while (!o_ready);
        expect_resp = apply_frame(f);
        pending_responses = {pending_responses, expect_resp};
    endtask

    // idle the sender until every response is back and the block has settled
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, logic [31:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (index == CFG_CHANNELS) begin
            tbl_channels = value[3:0];
            clear_table();
        end else begin
            tbl_timeout = value;
        end
    endtask

    function automatic t_frame make_frame(logic [2:0] op, int peer, logic [7:0] ch,
                                          logic [7:0] seq, logic [15:0] flen, logic dok);
        t_frame f;
        f.op = op;
        f.addr = peer_addr[peer];
        f.port = peer_port[peer];
        f.ch = ch;
        f.seq = seq;
        f.flen = flen;
        f.dok = dok;
        f.now = clock_ms;
        return f;
    endfunction

    task automatic test_connect();
        // fill the table, reuse an endpoint, overflow, short frames
        for (int p = 0; p < 4; p++)
            send_frame(make_frame(OP_CONNECT, p, 8'd0, 8'd0, 16'd26, 1'b0));
        send_frame(make_frame(OP_CONNECT, 1, 8'd0, 8'd0, 16'hFFFF, 1'b0));
        send_frame(make_frame(OP_CONNECT, 4, 8'd0, 8'd0, 16'd25, 1'b1));
        send_frame(make_frame(OP_CONNECT, 4, 8'd0, 8'd0, 16'd0, 1'b1));
        send_frame(make_frame(OP_CONNECT, 4, 8'd0, 8'd0, 16'd100, 1'b1));
        send_frame(make_frame(OP_CONNECT, 5, 8'd0, 8'd0, 16'd100, 1'b1));
    endtask

    task automatic test_control();
        send_frame(make_frame(OP_STATE, 0, 8'd1, 8'd0, 16'd16, 1'b0));
        send_frame(make_frame(OP_STATE, 0, 8'd1, 8'd0, 16'd15, 1'b0));
        send_frame(make_frame(OP_STATE, 1, 8'd1, 8'd0, 16'd16, 1'b0));
        send_frame(make_frame(OP_STATE, 0, 8'd0, 8'd0, 16'd16, 1'b0));
        send_frame(make_frame(OP_DISCONNECT, 1, 8'd255, 8'd0, 16'd40, 1'b0));
        send_frame(make_frame(OP_DISCONNECT, 1, 8'd2, 8'd0, 16'd40, 1'b0));
        send_frame(make_frame(OP_CONNECT, 5, 8'd0, 8'd0, 16'd26, 1'b0));
    endtask

    task automatic test_tunnel();
        send_frame(make_frame(OP_TUNNEL, 0, 8'd1, 8'd0, 16'd0, 1'b1));
        send_frame(make_frame(OP_TUNNEL, 0, 8'd1, 8'd0, 16'd0, 1'b1));
        send_frame(make_frame(OP_TUNNEL, 0, 8'd1, 8'd255, 16'd0, 1'b0));
        send_frame(make_frame(OP_TUNNEL, 2, 8'd1, 8'd1, 16'd0, 1'b1));
        send_frame(make_frame(OP_SEND, 0, 8'd1, 8'd0, 16'd0, 1'b0));
        send_frame(make_frame(OP_SEND, 0, 8'd9, 8'd0, 16'd0, 1'b0));
        send_frame(make_frame(OP_TICK, 0, 8'd0, 8'd0, 16'd0, 1'b0));
        send_frame(make_frame(OP_TICK_ALT6, 0, 8'd0, 8'd0, 16'd0, 1'b0));
        send_frame(make_frame(OP_TICK_ALT7, 0, 8'd0, 8'd0, 16'd0, 1'b0));
    endtask

    task automatic test_zero_channels();
        write_register(CFG_CHANNELS, 32'd0);
        send_frame(make_frame(OP_CONNECT, 0, 8'd0, 8'd0, 16'd30, 1'b0));
        send_frame(make_frame(OP_SEND, 0, 8'd1, 8'd0, 16'd0, 1'b0));
    endtask

    // random frames, mostly well formed against the mirrored table
    task automatic test_random(int count, int max_step, int noise_pct);
        t_frame f;
        int pick;
        int s;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) f.op = OP_CONNECT;
            else if (pick < 30) f.op = OP_STATE;
            else if (pick < 37) f.op = OP_DISCONNECT;
            else if (pick < 72) f.op = OP_TUNNEL;
            else if (pick < 92) f.op = OP_SEND;
            else f.op = 3'($urandom_range(5, 7));
            if ($urandom_range(0, 99) < noise_pct) begin
                f.addr = $urandom;
                f.port = 16'($urandom);
            end else begin
                pick = $urandom_range(0, 5);
                f.addr = peer_addr[pick];
                f.port = peer_port[pick];
            end
            if ($urandom_range(0, 99) < noise_pct) f.ch = 8'($urandom);
            else f.ch = 8'($urandom_range(1, (table_depth() == 0) ? 1 : table_depth()));
            // line a control frame up with the endpoint of its slot
            s = live_slot(f.ch);
            if (s >= 0 && f.op != OP_CONNECT && $urandom_range(0, 99) >= noise_pct) begin
                f.addr = tbl_addr[s];
                f.port = tbl_port[s];
            end
            if (s >= 0 && $urandom_range(0, 99) >= noise_pct + 10) f.seq = tbl_rx_seq[s];
            else f.seq = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < noise_pct) f.flen = 16'($urandom);
            else if (pick < noise_pct + 8) f.flen = 16'($urandom_range(14, 27));
            else f.flen = 16'($urandom_range(26, 1500));
            f.dok = ($urandom_range(0, 99) >= noise_pct / 2);
            clock_ms = clock_ms + 32'($urandom_range(0, max_step));
            f.now = clock_ms;
            send_frame(f);
            if (n == count / 2) drain();
        end
    endtask

    initial begin
        peer_addr = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hC0A8_0101, 32'hC0A8_0101,
                      32'h0A00_0002, 32'h5AA5_A55A};
        peer_port = '{16'h0000, 16'hFFFF, 16'h0E57, 16'h0E58, 16'hA5A5, 16'h5A5A};
        tbl_channels = 4'd8;
        tbl_timeout = '0;
        clear_table();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_register(CFG_CHANNELS, 32'd4);
        test_connect();
        test_control();
        test_tunnel();
        test_zero_channels();

        write_register(CFG_CHANNELS, 32'd8);
        test_random(600, 3, 10);

        write_register(CFG_CHANNELS, 32'd3);
        write_register(CFG_TIMEOUT, 32'd40);
        test_random(350, 8, 15);

        // wrap of the time counter and the largest timeout
        write_register(CFG_CHANNELS, 32'd15);
        write_register(CFG_TIMEOUT, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FF00;
        test_random(300, 4, 20);

        write_register(CFG_CHANNELS, 32'd1);
        write_register(CFG_TIMEOUT, 32'd1);
        test_random(150, 1, 10);

        write_register(CFG_CHANNELS, 32'd6);
        write_register(CFG_TIMEOUT, 32'd0);
        clock_ms = $urandom;
        test_random(130, 100000, 25);

        drain();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
